// File: src/purt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package purt_pkg;

    localparam int VISIBLE_LINES   = 240;
    localparam int LINES_PER_FRAME = 262;
    localparam int DOTS_PER_LINE   = 341;
    localparam int NAME_BYTES      = 2048;
    localparam int NAME_AW         = $clog2(NAME_BYTES);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADR = 3'd3;
    localparam logic [2:0] REG_OAMDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // issue memory read, compute everything but read-dependent state
        logic finish; // apply read data and form the result
    } ctl_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_request;
        logic [8:0] line_now;
        logic [8:0] dot_now;
    } result_t;

    function automatic logic [NAME_AW-1:0] name_index(logic [14:0] a, logic [1:0] mode);
        logic [11:0] off;
        off = a[11:0];
        if (mode == 2'd1)
            return {off[11], off[9:0]};
        return off[10:0];
    endfunction

    function automatic logic [4:0] pal_index(logic [14:0] a);
        logic [4:0] p;
        p = a[4:0];
        if ((p & 5'h13) == 5'h10)
            p = p ^ 5'h10;
        return p;
    endfunction

endpackage
`default_nettype wire

// File: src/purt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface purt_in_if;
    import purt_pkg::*;
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface purt_out_if;
    import purt_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/picture_unit_registers_and_timing_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel     Dir  Payload                                      Handshake
// in_ch       in   command, reg_select, write_data              valid/ready
// out_ch      out  read_data, nmi_request, line_now, dot_now    valid/ready
// cfg         in   mirror_mode (2 bits)                         cfg_we only
//
// Each beat passes in order through the steps capture (the
// beat is taken), execute (memories are read and written, register state
// updated), finish (registered memory data resolves the read and the read
// buffer), and output. The result is offered in the output state, and the
// next beat is taken only from idle, which is entered once the result has
// been taken, so no new beat is accepted while one is in flight. The
// registered single-port memory read is why the finish state exists.
// An output stall holds the result and blocks the input. Reset leaves the block
// at dot 0 of the pre-render line with vblank set; the memories are not cleared.
module picture_unit_registers_and_timing_unit
    import purt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    purt_in_if.sink         in_ch,
    purt_out_if.source      out_ch,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data
);
    ctl_t ctl;

    purt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .ctl(ctl));

    purt_dp u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .item(in_ch.payload),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .result(out_ch.payload));
endmodule
`default_nettype wire

// File: src/purt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module purt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: src/purt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module purt_ctrl
    import purt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctl_t      ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");
    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec)
        else $error("execute did not follow load");
    a_finish_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> ctl.finish)
        else $error("finish did not follow execute");
endmodule
`default_nettype wire

// File: src/purt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module purt_dp
    import purt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctl_t       ctl,
    input  wire item_t      item,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data,
    output result_t         result
);
    item_t       item_reg;
    logic [1:0]  mirror_reg;
    logic [7:0]  ctrl_reg, mask_reg, status_reg, oam_addr_reg, buf_reg, rd_reg;
    logic [14:0] v_reg, t_reg;
    logic [2:0]  fx_reg, fxc_reg;
    logic        w_reg, nmi_reg, nmi_last_reg, armed_reg, odd_reg;
    logic [8:0]  line_reg, dot_reg;
    logic [14:0] rd_addr_reg; // VRAM address latched for the data read
    logic [7:0]  ctrl_next, mask_next, status_next, oam_addr_next, rd_next;
    logic [14:0] v_next, t_next;
    logic [2:0]  fx_next, fxc_next;
    logic        w_next, nmi_next, nmi_last_next, armed_next, odd_next;
    logic [8:0]  line_next, dot_next;

    logic        is_rd, is_wr, is_tick;
    logic [13:0] va;
    logic        oam_we, nt_we, pal_we;
    logic [7:0]  oam_q, nt_q, pal_q;
    logic        rendering, level;
    logic [8:0]  max_dot;
    logic [4:0]  y;
    logic [7:0]  fetched;

    assign is_rd   = item_reg.command == CMD_READ;
    assign is_wr   = item_reg.command == CMD_WRITE;
    assign is_tick = item_reg.command == CMD_TICK;
    assign va      = v_reg[13:0];
    assign oam_we  = ctl.exec && is_wr && item_reg.reg_select == REG_OAMDAT;
    assign nt_we   = ctl.exec && is_wr && item_reg.reg_select == REG_DATA
                     && va >= 14'h2000 && va < 14'h3F00;
    assign pal_we  = ctl.exec && is_wr && item_reg.reg_select == REG_DATA
                     && va >= 14'h3F00;

    purt_ram #(.WIDTH(8), .DEPTH(256)) u_oam (
        .clk(clk), .we(oam_we), .addr(oam_addr_reg),
        .wdata(item_reg.write_data), .rdata(oam_q));
    purt_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_nt (
        .clk(clk), .we(nt_we), .addr(name_index(v_reg, mirror_reg)),
        .wdata(item_reg.write_data), .rdata(nt_q));
    purt_ram #(.WIDTH(8), .DEPTH(32)) u_pal (
        .clk(clk), .we(pal_we), .addr(pal_index(v_reg)),
        .wdata(item_reg.write_data), .rdata(pal_q));

    assign rendering = (line_reg < 9'(VISIBLE_LINES) || line_reg == 9'(LINES_PER_FRAME - 1))
                       && (mask_reg & 8'h18) != 8'h00;

    always_comb
    begin
        if (rd_addr_reg[13:0] < 14'h2000)
            fetched = 8'h00;
        else if (rd_addr_reg[13:0] < 14'h3F00)
            fetched = nt_q;
        else
            fetched = pal_q;
    end

    always_comb
    begin
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        oam_addr_next = oam_addr_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        fx_next       = fx_reg;
        fxc_next      = fxc_reg;
        w_next        = w_reg;
        nmi_next      = nmi_reg;
        nmi_last_next = nmi_last_reg;
        armed_next    = armed_reg;
        odd_next      = odd_reg;
        line_next     = line_reg;
        dot_next      = dot_reg;
        rd_next       = 8'h00;
        max_dot       = 9'(DOTS_PER_LINE);
        y             = 5'd0;
        level         = 1'b0;
        if (is_rd)
        begin
            unique case (item_reg.reg_select)
                REG_STATUS:
                begin
                    rd_next = status_reg;
                    if (armed_reg)
                    begin
                        status_next[7] = 1'b0;
                        armed_next     = 1'b0;
                    end
                    if (status_reg[7])
                        armed_next = 1'b1;
                    w_next   = 1'b0;
                    nmi_next = 1'b0;
                end
                REG_DATA:
                    v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                default: ;
            endcase
        end
        else if (is_wr)
        begin
            unique case (item_reg.reg_select)
                REG_CTRL:
                begin
                    ctrl_next     = item_reg.write_data;
                    t_next[11:10] = item_reg.write_data[1:0];
                    level         = item_reg.write_data[7] & status_reg[7];
                    if (level && !nmi_last_reg)
                        nmi_next = 1'b1;
                    nmi_last_next = level;
                end
                REG_MASK:   mask_next = item_reg.write_data;
                REG_OAMADR: oam_addr_next = item_reg.write_data;
                REG_OAMDAT: oam_addr_next = oam_addr_reg + 8'd1;
                REG_SCROLL:
                begin
                    if (!w_reg)
                    begin
                        t_next[4:0] = item_reg.write_data[7:3];
                        fx_next     = item_reg.write_data[2:0];
                        fxc_next    = item_reg.write_data[2:0];
                        w_next      = 1'b1;
                    end
                    else
                    begin
                        t_next[14:12] = item_reg.write_data[2:0];
                        t_next[9:5]   = item_reg.write_data[7:3];
                        w_next        = 1'b0;
                    end
                end
                REG_ADDR:
                begin
                    if (!w_reg)
                    begin
                        t_next[14]   = 1'b0;
                        t_next[13:8] = item_reg.write_data[5:0];
                        w_next       = 1'b1;
                    end
                    else
                    begin
                        t_next[7:0] = item_reg.write_data;
                        v_next      = {t_reg[14:8], item_reg.write_data};
                        w_next      = 1'b0;
                    end
                end
                REG_DATA: v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                default: ;
            endcase
        end
        else if (is_tick)
        begin
            if (line_reg == 9'(LINES_PER_FRAME - 1) && odd_reg && rendering)
                max_dot = 9'(DOTS_PER_LINE - 1);
            if (line_reg == 9'(VISIBLE_LINES + 1) && dot_reg == 9'd1)
            begin
                status_next[7] = 1'b1;
                armed_next     = 1'b0;
                level          = ctrl_reg[7];
                if (level && !nmi_last_reg)
                    nmi_next = 1'b1;
                nmi_last_next = level;
            end
            if (line_reg == 9'(LINES_PER_FRAME - 1) && dot_reg == 9'd1)
            begin
                status_next   = status_reg & 8'h1F;
                nmi_last_next = 1'b0;
                armed_next    = 1'b0;
            end
            if (rendering && line_reg < 9'(VISIBLE_LINES) && dot_reg == 9'd256)
            begin
                if (v_reg[14:12] != 3'd7)
                    v_next[14:12] = v_reg[14:12] + 3'd1;
                else
                begin
                    v_next[14:12] = 3'd0;
                    y = v_reg[9:5];
                    if (y == 5'd29)
                    begin
                        y          = 5'd0;
                        v_next[11] = ~v_reg[11];
                    end
                    else if (y == 5'd31)
                        y = 5'd0;
                    else
                        y = y + 5'd1;
                    v_next[9:5] = y;
                end
            end
            if (rendering && dot_reg == 9'd257)
            begin
                v_next   = (v_next & ~15'h041F) | (t_reg & 15'h041F);
                fxc_next = fx_reg;
            end
            if (rendering && line_reg == 9'(LINES_PER_FRAME - 1)
                && dot_reg >= 9'd280 && dot_reg <= 9'd304)
                v_next = (v_next & ~15'h7BE0) | (t_reg & 15'h7BE0);
            dot_next = dot_reg + 9'd1;
            if (dot_next >= max_dot)
            begin
                dot_next  = 9'd0;
                line_next = line_reg + 9'd1;
                if (line_next >= 9'(LINES_PER_FRAME))
                begin
                    line_next = 9'd0;
                    odd_next  = ~odd_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= item;
        if (ctl.exec)
            rd_addr_reg <= v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg   <= 2'd0;
            ctrl_reg     <= 8'h00;
            mask_reg     <= 8'h00;
            status_reg   <= 8'h80;
            oam_addr_reg <= 8'h00;
            buf_reg      <= 8'h00;
            rd_reg       <= 8'h00;
            v_reg        <= 15'd0;
            t_reg        <= 15'd0;
            fx_reg       <= 3'd0;
            fxc_reg      <= 3'd0;
            w_reg        <= 1'b0;
            nmi_reg      <= 1'b0;
            nmi_last_reg <= 1'b0;
            armed_reg    <= 1'b0;
            odd_reg      <= 1'b0;
            line_reg     <= 9'(LINES_PER_FRAME - 1);
            dot_reg      <= 9'd0;
        end
        else
        begin
            if (cfg_we)
                mirror_reg <= cfg_data;
            if (ctl.exec)
            begin
                ctrl_reg     <= ctrl_next;
                mask_reg     <= mask_next;
                status_reg   <= status_next;
                oam_addr_reg <= oam_addr_next;
                v_reg        <= v_next;
                t_reg        <= t_next;
                fx_reg       <= fx_next;
                fxc_reg      <= fxc_next;
                w_reg        <= w_next;
                nmi_reg      <= nmi_next;
                nmi_last_reg <= nmi_last_next;
                armed_reg    <= armed_next;
                odd_reg      <= odd_next;
                line_reg     <= line_next;
                dot_reg      <= dot_next;
                rd_reg       <= rd_next;
            end
            if (ctl.finish && is_rd)
            begin
                if (item_reg.reg_select == REG_OAMDAT)
                    rd_reg <= oam_q;
                else if (item_reg.reg_select == REG_DATA)
                begin
                    buf_reg <= fetched;
                    rd_reg  <= (rd_addr_reg[13:0] >= 14'h3F00) ? fetched : buf_reg;
                end
            end
        end
    end

    assign result = '{read_data: rd_reg, nmi_request: nmi_reg,
                      line_now: line_reg, dot_now: dot_reg};

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < 9'(LINES_PER_FRAME))
        else $error("scanline out of range");
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg < 9'(DOTS_PER_LINE))
        else $error("dot out of range");
    a_status_low: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[4:0] == 5'd0)
        else $error("status low bits set");
endmodule
`default_nettype wire
